// File: hdl/slab_bitmap_slot_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Slab bitmap slot allocator assertion macros
// Shorthand for the concurrent assertions of the port checker.
// ----------------------------------------------------------------------------
`ifndef SLAB_BITMAP_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define SLAB_BITMAP_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// Checked on every rising edge while reset is low.
`define SBSA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SBSA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/sbsa_pkg.sv
// ----------------------------------------------------------------------------
// Slab bitmap slot allocator package
// Field widths, reset values, codes and the shared ALU request and response.
// ----------------------------------------------------------------------------
package sbsa_pkg;

   localparam int ADDR_W      = 57;
   localparam int STATUS_W    = 2;
   localparam int BIDX_W      = 12;
   localparam int FREE_W      = 13;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 57;
   localparam int SIZE_LOG2_W = 5;
   localparam int COUNT_W     = 13;
   localparam int BACK_LOG2_W = 6;
   localparam int DATA_W      = 64;
   localparam int SHAMT_W     = 6;
   localparam int ROW_W       = 64;
   localparam int ROW_BIT_W   = 6;
   localparam int SUMMARY_W   = 64;

   localparam logic [ADDR_W-1:0]      WINDOW_BASE_RST = '0;
   localparam logic [SIZE_LOG2_W-1:0] SLOT_SIZE_RST   = 5'd9;
   localparam logic [COUNT_W-1:0]     SLOT_COUNT_RST  = 13'd4096;
   localparam logic [BACK_LOG2_W-1:0] BACKING_RST     = 6'd21;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_OUTSIDE = 2'd2,
      STATUS_DOUBLE  = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_BASE    = 2'd0,
      CSR_SLOT_SIZE_LOG2 = 2'd1,
      CSR_SLOT_COUNT     = 2'd2,
      CSR_BACKING_LOG2   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_SUB = 2'd1,
      ALU_SHL = 2'd2,
      ALU_SHR = 2'd3
   } alu_op_type;

   typedef struct packed {
      alu_op_type        op;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic              borrow;
   } alu_rsp_type;

endpackage

// File: hdl/sbsa_if.sv
// ----------------------------------------------------------------------------
// Slab bitmap slot allocator channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sbsa_req_if;
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [sbsa_pkg::ADDR_W-1:0]  free_addr;

   modport source (output valid, output req_type, output free_addr, input ready);
   modport sink   (input valid, input req_type, input free_addr, output ready);
endinterface

interface sbsa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sbsa_pkg::STATUS_W-1:0] status;
   logic [sbsa_pkg::ADDR_W-1:0]   slot_addr;
   logic [sbsa_pkg::BIDX_W-1:0]   backing_index;
   logic [sbsa_pkg::FREE_W-1:0]   free_slots;

   modport source (output valid, output status, output slot_addr, output backing_index,
                   output free_slots, input ready);
   modport sink   (input valid, input status, input slot_addr, input backing_index,
                   input free_slots, output ready);
endinterface

// File: hdl/sbsa_alu.sv
// ----------------------------------------------------------------------------
// Slab bitmap slot allocator shared ALU
// 64-bit add, subtract with borrow, and left and right shift.
// ----------------------------------------------------------------------------
module sbsa_alu (
   input  sbsa_pkg::alu_req_type alu_req,
   output sbsa_pkg::alu_rsp_type alu_rsp
);

   localparam int DW = sbsa_pkg::DATA_W;

   logic [DW:0] diff;

   assign diff = {1'b0, alu_req.a} - {1'b0, alu_req.b};

   always_comb begin
      alu_rsp.borrow = 1'b0;
      unique case (alu_req.op)
         sbsa_pkg::ALU_ADD: begin
            alu_rsp.result = alu_req.a + alu_req.b;
         end
         sbsa_pkg::ALU_SUB: begin
            alu_rsp.result = diff[DW-1:0];
            alu_rsp.borrow = diff[DW];
         end
         sbsa_pkg::ALU_SHL: begin
            alu_rsp.result = alu_req.a << alu_req.b[sbsa_pkg::SHAMT_W-1:0];
         end
         sbsa_pkg::ALU_SHR: begin
            alu_rsp.result = alu_req.a >> alu_req.b[sbsa_pkg::SHAMT_W-1:0];
         end
         default: begin
            alu_rsp.result = '0;
         end
      endcase
   end

endmodule

// File: hdl/sbsa_ffz.sv
// ----------------------------------------------------------------------------
// Slab bitmap slot allocator find-first-zero
// Returns the lowest clear bit of a vector and whether one exists.
// ----------------------------------------------------------------------------
module sbsa_ffz #(
   parameter  int WIDTH = 64,
   localparam int IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
   input  logic [WIDTH-1:0] bits,
   output logic             found,
   output logic [IDX_W-1:0] index
);

   always_comb begin
      found = 1'b0;
      index = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (!bits[i]) begin
            found = 1'b1;
            index = IDX_W'(i);
         end
      end
   end

endmodule

// File: hdl/sbsa_bitmap.sv
// ----------------------------------------------------------------------------
// Slab bitmap slot allocator occupancy memory
// One write port and one registered read port over 64-bit bitmap rows.
// ----------------------------------------------------------------------------
module sbsa_bitmap #(
   parameter  int DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [sbsa_pkg::ROW_W-1:0]   wr_data,
   input  logic [AW-1:0]                rd_addr,
   output logic [sbsa_pkg::ROW_W-1:0]   rd_data
);

   logic [sbsa_pkg::ROW_W-1:0] mem [DEPTH];
   logic [sbsa_pkg::ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/slab_bitmap_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// Slab bitmap slot allocator unit
// Sequence: an allocate scans the 64-row summary groups in A_SCAN, reads the chosen row, takes its
// lowest clear bit, forms the address in ADDR1 to ADDR3 and answers from DONE; a free subtracts
// the base, shifts, reads the row, checks the bit and then runs the same address states.
// Throughput: one word in work at a time, and ready returns with the response word. Failures end
// sooner, and a stalled response delays the next word.
// Reset: synchronous; afterwards the bitmap is swept clear one row a cycle, with req ready low;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module slab_bitmap_slot_allocator_unit #(
   parameter int MAX_SLOTS = 4096,
   parameter int ADDR_BITS = 57
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [sbsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sbsa_pkg::CSR_DATA_W-1:0]   csr_wdata,
   sbsa_req_if.sink                          req_chan,
   sbsa_rsp_if.source                        rsp_chan
);

   // The occupancy map is held as 64-bit rows in a memory. A summary vector in
   // flip-flops marks every row that is completely used, so an allocate first
   // finds the lowest row that is not full (64 summary bits per cycle), then
   // reads that row and takes its lowest clear bit. Rows past the end of the
   // map are marked full for good and are never chosen.
   localparam int DW       = sbsa_pkg::DATA_W;
   localparam int AW       = sbsa_pkg::ADDR_W;
   localparam int RW       = sbsa_pkg::ROW_W;
   localparam int RBW      = sbsa_pkg::ROW_BIT_W;
   localparam int ROWS     = (MAX_SLOTS + RW - 1) / RW;
   localparam int ROWIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int GW       = (ROWS >= sbsa_pkg::SUMMARY_W) ? sbsa_pkg::SUMMARY_W : ROWS;
   localparam int GROUPS   = (ROWS + GW - 1) / GW;
   localparam int GIDX_W   = (GW > 1) ? $clog2(GW) : 1;
   localparam int GRP_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int SUM_BITS = GROUPS * GW;
   localparam int SLOT_W   = ROWIDX_W + RBW;
   localparam int CNT_W    = ($clog2(MAX_SLOTS + 1) > sbsa_pkg::COUNT_W) ?
                             $clog2(MAX_SLOTS + 1) : sbsa_pkg::COUNT_W;
   localparam int EFF_BITS = (ADDR_BITS < AW) ? ADDR_BITS : AW;
   localparam logic [DW-1:0]    ADDR_MASK = (DW'(1) << EFF_BITS) - DW'(1);
   localparam logic [CNT_W-1:0] MAX_N     = CNT_W'(MAX_SLOTS);

   typedef enum logic [12:0] {
      ST_CLEAR  = 13'b0000000000001,
      ST_IDLE   = 13'b0000000000010,
      ST_A_SCAN = 13'b0000000000100,
      ST_A_RD   = 13'b0000000001000,
      ST_A_FIND = 13'b0000000010000,
      ST_F_SUB  = 13'b0000000100000,
      ST_F_SHR  = 13'b0000001000000,
      ST_F_RD   = 13'b0000010000000,
      ST_F_CHK  = 13'b0000100000000,
      ST_ADDR1  = 13'b0001000000000,
      ST_ADDR2  = 13'b0010000000000,
      ST_ADDR3  = 13'b0100000000000,
      ST_DONE   = 13'b1000000000000
   } state_type;

   // Configuration registers.
   logic [AW-1:0]                       window_base_ff;
   logic [sbsa_pkg::SIZE_LOG2_W-1:0]    slot_size_log2_ff;
   logic [sbsa_pkg::COUNT_W-1:0]        slot_count_ff;
   logic [sbsa_pkg::BACK_LOG2_W-1:0]    backing_block_log2_ff;

   // Control state.
   state_type             state_ff, state_in;
   logic [ROWIDX_W-1:0]   clr_ff, clr_in;
   logic [GRP_W-1:0]      grp_ff, grp_in;
   logic [SUM_BITS-1:0]   full_ff, full_in;
   logic [CNT_W-1:0]      used_ff, used_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Work and result payload.
   logic [ROWIDX_W-1:0]        row_ff, row_in;
   logic [RBW-1:0]             bit_ff, bit_in;
   logic [DW-1:0]              addr_ff, addr_in;
   logic [DW-1:0]              off_ff, off_in;
   logic [AW-1:0]              out_addr_ff, out_addr_in;
   logic [sbsa_pkg::BIDX_W-1:0] out_bidx_ff, out_bidx_in;
   sbsa_pkg::status_type       status_ff, status_in;
   sbsa_pkg::status_type       rsp_status_ff, rsp_status_in;
   logic [AW-1:0]              rsp_addr_ff, rsp_addr_in;
   logic [sbsa_pkg::BIDX_W-1:0] rsp_bidx_ff, rsp_bidx_in;
   logic [sbsa_pkg::FREE_W-1:0] rsp_free_ff, rsp_free_in;

   // Datapath.
   sbsa_pkg::alu_req_type alu_req;
   sbsa_pkg::alu_rsp_type alu_rsp;
   logic [CNT_W-1:0]      n_slots;
   logic [DW-1:0]         base_m;
   logic [GW-1:0]         grp_bits;
   logic                  grp_found;
   logic [GIDX_W-1:0]     grp_idx;
   logic [RW-1:0]         rd_data;
   logic                  bit_found;
   logic [RBW-1:0]        bit_idx;
   logic [SLOT_W-1:0]     cand_slot;
   logic [RW-1:0]         set_row;
   logic                  mem_wr_en;
   logic [ROWIDX_W-1:0]   mem_wr_addr;
   logic [RW-1:0]         mem_wr_data;
   logic                  req_fire;
   logic                  rsp_free_slot;

   // Active slot range is slot_count clamped to the map size.
   assign n_slots   = (CNT_W'(slot_count_ff) > MAX_N) ? MAX_N : CNT_W'(slot_count_ff);
   assign base_m    = DW'(window_base_ff) & ADDR_MASK;
   assign grp_bits  = full_ff[int'(grp_ff) * GW +: GW];
   assign cand_slot = {row_ff, bit_idx};
   assign set_row   = rd_data | (RW'(1) << bit_idx);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free_slot  = !rsp_valid_ff || rsp_chan.ready;

   sbsa_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   sbsa_ffz #(.WIDTH(GW)) u_grp_ffz (
      .bits  (grp_bits),
      .found (grp_found),
      .index (grp_idx)
   );

   sbsa_ffz #(.WIDTH(RW)) u_row_ffz (
      .bits  (rd_data),
      .found (bit_found),
      .index (bit_idx)
   );

   sbsa_bitmap #(.DEPTH(ROWS)) u_bitmap (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (row_ff),
      .rd_data (rd_data)
   );

   // Sequencer: F_SUB, F_SHR, ADDR1 to ADDR3 and DONE each hand one operation to the shared ALU.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      grp_in        = grp_ff;
      full_in       = full_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      row_in        = row_ff;
      bit_in        = bit_ff;
      addr_in       = addr_ff;
      off_in        = off_ff;
      out_addr_in   = out_addr_ff;
      out_bidx_in   = out_bidx_ff;
      status_in     = status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_bidx_in   = rsp_bidx_ff;
      rsp_free_in   = rsp_free_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = row_ff;
      mem_wr_data   = '0;
      alu_req.op    = sbsa_pkg::ALU_ADD;
      alu_req.a     = '0;
      alu_req.b     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == ROWIDX_W'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               addr_in     = DW'(req_chan.free_addr) & ADDR_MASK;
               grp_in      = '0;
               out_addr_in = '0;
               out_bidx_in = '0;
               status_in   = sbsa_pkg::STATUS_OK;
               state_in    = req_chan.req_type ? ST_F_SUB : ST_A_SCAN;
            end
         end
         ST_A_SCAN: begin
            if (grp_found) begin
               row_in   = ROWIDX_W'(int'(grp_ff) * GW + int'(grp_idx));
               state_in = ST_A_RD;
            end else if (grp_ff == GRP_W'(GROUPS - 1)) begin
               status_in = sbsa_pkg::STATUS_FULL;
               state_in  = ST_DONE;
            end else begin
               grp_in = grp_ff + 1'b1;
            end
         end
         ST_A_RD: begin
            state_in = ST_A_FIND;
         end
         ST_A_FIND: begin
            // The lowest clear bit past the active range means every active slot is used.
            if (bit_found && (DW'(cand_slot) < DW'(n_slots))) begin
               bit_in           = bit_idx;
               mem_wr_en        = 1'b1;
               mem_wr_data      = set_row;
               full_in[row_ff]  = &set_row;
               used_in          = used_ff + 1'b1;
               state_in         = ST_ADDR1;
            end else begin
               status_in = sbsa_pkg::STATUS_FULL;
               state_in  = ST_DONE;
            end
         end
         ST_F_SUB: begin
            alu_req.op = sbsa_pkg::ALU_SUB;
            alu_req.a  = addr_ff;
            alu_req.b  = base_m;
            off_in     = alu_rsp.result;
            if (alu_rsp.borrow) begin
               status_in = sbsa_pkg::STATUS_OUTSIDE;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_F_SHR;
            end
         end
         ST_F_SHR: begin
            alu_req.op = sbsa_pkg::ALU_SHR;
            alu_req.a  = off_ff;
            alu_req.b  = DW'(slot_size_log2_ff);
            row_in     = alu_rsp.result[SLOT_W-1:RBW];
            bit_in     = alu_rsp.result[RBW-1:0];
            if (alu_rsp.result >= DW'(n_slots)) begin
               status_in = sbsa_pkg::STATUS_OUTSIDE;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_F_RD;
            end
         end
         ST_F_RD: begin
            state_in = ST_F_CHK;
         end
         ST_F_CHK: begin
            if (!rd_data[bit_ff]) begin
               status_in = sbsa_pkg::STATUS_DOUBLE;
               state_in  = ST_DONE;
            end else begin
               mem_wr_en       = 1'b1;
               mem_wr_data     = rd_data & ~(RW'(1) << bit_ff);
               full_in[row_ff] = 1'b0;
               if (used_ff != '0) begin
                  used_in = used_ff - 1'b1;
               end
               state_in = ST_ADDR1;
            end
         end
         ST_ADDR1: begin
            alu_req.op = sbsa_pkg::ALU_SHL;
            alu_req.a  = DW'({row_ff, bit_ff});
            alu_req.b  = DW'(slot_size_log2_ff);
            off_in     = alu_rsp.result;
            state_in   = ST_ADDR2;
         end
         ST_ADDR2: begin
            alu_req.op  = sbsa_pkg::ALU_ADD;
            alu_req.a   = base_m;
            alu_req.b   = off_ff;
            out_addr_in = AW'(alu_rsp.result & ADDR_MASK);
            state_in    = ST_ADDR3;
         end
         ST_ADDR3: begin
            alu_req.op  = sbsa_pkg::ALU_SHR;
            alu_req.a   = off_ff;
            alu_req.b   = DW'(backing_block_log2_ff);
            out_bidx_in = alu_rsp.result[sbsa_pkg::BIDX_W-1:0];
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // Free slots left is the active range minus the used count, floored at zero.
            alu_req.op = sbsa_pkg::ALU_SUB;
            alu_req.a  = DW'(n_slots);
            alu_req.b  = DW'(used_ff);
            if (rsp_free_slot) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_addr_in   = out_addr_ff;
               rsp_bidx_in   = out_bidx_ff;
               rsp_free_in   = alu_rsp.borrow ? '0 : alu_rsp.result[sbsa_pkg::FREE_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_base_ff        <= sbsa_pkg::WINDOW_BASE_RST;
         slot_size_log2_ff     <= sbsa_pkg::SLOT_SIZE_RST;
         slot_count_ff         <= sbsa_pkg::SLOT_COUNT_RST;
         backing_block_log2_ff <= sbsa_pkg::BACKING_RST;
         state_ff              <= ST_CLEAR;
         clr_ff                <= '0;
         grp_ff                <= '0;
         used_ff               <= '0;
         rsp_valid_ff          <= 1'b0;
         for (int i = 0; i < SUM_BITS; i++) begin
            full_ff[i] <= (i >= ROWS);
         end
      end else begin
         if (csr_wr_en) begin
            unique case (sbsa_pkg::csr_index_type'(csr_index))
               sbsa_pkg::CSR_WINDOW_BASE: begin
                  window_base_ff <= csr_wdata[AW-1:0];
               end
               sbsa_pkg::CSR_SLOT_SIZE_LOG2: begin
                  slot_size_log2_ff <= csr_wdata[sbsa_pkg::SIZE_LOG2_W-1:0];
               end
               sbsa_pkg::CSR_SLOT_COUNT: begin
                  slot_count_ff <= csr_wdata[sbsa_pkg::COUNT_W-1:0];
               end
               sbsa_pkg::CSR_BACKING_LOG2: begin
                  backing_block_log2_ff <= csr_wdata[sbsa_pkg::BACK_LOG2_W-1:0];
               end
               default: begin
                  window_base_ff <= window_base_ff;
               end
            endcase
         end
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         grp_ff       <= grp_in;
         full_ff      <= full_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      bit_ff        <= bit_in;
      addr_ff       <= addr_in;
      off_ff        <= off_in;
      out_addr_ff   <= out_addr_in;
      out_bidx_ff   <= out_bidx_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_bidx_ff   <= rsp_bidx_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.slot_addr     = rsp_addr_ff;
   assign rsp_chan.backing_index = rsp_bidx_ff;
   assign rsp_chan.free_slots    = rsp_free_ff;

endmodule

// File: hdl/sbsa_checker.sv
// ----------------------------------------------------------------------------
// Slab bitmap slot allocator port checker
// Concurrent assertions on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
`include "slab_bitmap_slot_allocator_unit_macros.svh"

module sbsa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sbsa_pkg::STATUS_W-1:0] rsp_status,
   input logic [sbsa_pkg::ADDR_W-1:0]   rsp_slot_addr,
   input logic [sbsa_pkg::BIDX_W-1:0]   rsp_backing_index
);

   // The bitmap sweep after reset keeps the request side closed.
   `SBSA_ASSERT_ALWAYS(a_reset_not_ready, clock, reset |=> !req_ready, "ready right after reset")

   // Only one request word is in work, so ready drops after every accepted word.
   `SBSA_ASSERT(a_one_in_flight, clock, reset, req_valid && req_ready |=> !req_ready, "second word taken while busy")

   // A failed request reports neither an address nor a backing block.
   `SBSA_ASSERT(a_fail_zero, clock, reset, rsp_valid && (rsp_status != sbsa_pkg::STATUS_OK) |-> (rsp_slot_addr == '0) && (rsp_backing_index == '0), "failure word carries nonzero fields")

   // A stalled response word holds.
   `SBSA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot_addr), "stalled response word changed")

endmodule

bind slab_bitmap_slot_allocator_unit sbsa_checker u_sbsa_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_slot_addr     (rsp_chan.slot_addr),
   .rsp_backing_index (rsp_chan.backing_index)
);
